[src/chisq_kt_pkg.sv]
// Shared constants, types and a helper function of the weighted KT code-length core.
package chisq_kt_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int SYM_W         = $clog2(ALPHABET_SIZE);
    localparam int COUNT_BITS    = 24;
    localparam int FRAC_BITS     = 16;
    localparam int LEN_W         = 21;
    localparam int TOTAL_W       = 46;
    localparam int WEIGHT_W      = 25;
    localparam int LOG_FRAC      = 30;
    localparam int LOG_IN_W      = 64;
    localparam int LOG_POS_W     = 6;
    localparam int LOG_W         = LOG_POS_W + LOG_FRAC;
    localparam int LOG_CNT_W     = 5;
    localparam int DEND_W        = 66;
    localparam int SOR_W         = 64;
    localparam int DIV_CNT_W     = 7;
    localparam int LEN_SHIFT     = 57 - FRAC_BITS;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_ONE = WEIGHT_W'(1) << 24;
    localparam logic [26:0]           LN2_Q27    = 27'd93032640;
    localparam logic [LEN_W-1:0]      LEN_MAX    = '1;
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
    localparam logic [7:0]            DEGREES    = 8'(ALPHABET_SIZE - 1);

    typedef enum logic {
        KIND_LOAD,
        KIND_CODE
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [SYM_W-1:0]      symbol;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } item_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_W_RD,
        ST_W_PA_GO,
        ST_W_PA,
        ST_W_PB,
        ST_W_T1_GO,
        ST_W_T1,
        ST_W_T2_GO,
        ST_W_T2,
        ST_CORR_GO,
        ST_CORR,
        ST_E_LO,
        ST_E_HI,
        ST_XI_GO,
        ST_XI,
        ST_RD,
        ST_NUM,
        ST_LN_NUM,
        ST_LN_DEN,
        ST_M_LO,
        ST_M_HI,
        ST_OUT
    } back_state_t;

    typedef enum logic [1:0] {
        LOG_IDLE,
        LOG_NORM,
        LOG_SQ
    } log_state_t;

    function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

[src/chisq_kt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module chisq_kt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/chisq_kt_front.sv]
// Front end: accepts input items, classifies them and holds them in a two-entry queue.
module chisq_kt_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [7:0]                         symbol,
    input  logic [chisq_kt_pkg::COUNT_BITS-1:0] training_count,
    input  logic                               last_symbol,
    output logic                               q_valid,
    output chisq_kt_pkg::item_t                q_item,
    input  logic                               q_take
);

    chisq_kt_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    chisq_kt_pkg::item_t in_item;

    always_comb
    begin
        in_item.kind   = mode ? chisq_kt_pkg::KIND_CODE : chisq_kt_pkg::KIND_LOAD;
        in_item.symbol = symbol[chisq_kt_pkg::SYM_W-1:0];
        in_item.count  = training_count;
        in_item.last   = last_symbol;
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_valid && q_take;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[src/chisq_kt_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module chisq_kt_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [chisq_kt_pkg::DEND_W-1:0]  dividend,
    input  logic [chisq_kt_pkg::SOR_W-1:0]   divisor,
    output logic                             done,
    output logic [chisq_kt_pkg::DEND_W-1:0]  quotient
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [chisq_kt_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [chisq_kt_pkg::DEND_W-1:0]     dend_reg, dend_next;
    logic [chisq_kt_pkg::SOR_W-1:0]      sor_reg, sor_next;
    logic [chisq_kt_pkg::SOR_W-1:0]      rem_reg, rem_next;
    logic [chisq_kt_pkg::DEND_W-1:0]     quo_reg, quo_next;
    logic [chisq_kt_pkg::SOR_W:0]        trial;
    logic                                fits;

    assign trial = {rem_reg, dend_reg[chisq_kt_pkg::DEND_W-1]};
    assign fits  = (trial >= {1'b0, sor_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dend_next = dend_reg;
        sor_next  = sor_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (busy_reg)
        begin
            dend_next = dend_reg << 1;
            rem_next  = fits ? chisq_kt_pkg::SOR_W'(trial - {1'b0, sor_reg})
                             : trial[chisq_kt_pkg::SOR_W-1:0];
            quo_next  = {quo_reg[chisq_kt_pkg::DEND_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == chisq_kt_pkg::DIV_CNT_W'(chisq_kt_pkg::DEND_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dend_next = dividend;
            sor_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dend_reg <= dend_next;
        sor_reg  <= sor_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/chisq_kt_log.sv]
// Fixed-point base-two logarithm: stepwise normalisation, then one squaring per fraction bit.
module chisq_kt_log (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [chisq_kt_pkg::LOG_IN_W-1:0]  value,
    output logic                               done,
    output logic [chisq_kt_pkg::LOG_W-1:0]     result
);

    chisq_kt_pkg::log_state_t             state_reg, state_next;
    logic                                 done_reg, done_next;
    logic [chisq_kt_pkg::LOG_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [chisq_kt_pkg::LOG_IN_W-1:0]    v_reg, v_next;
    logic [chisq_kt_pkg::LOG_POS_W-1:0]   p_reg, p_next;
    logic [31:0]                          m_reg, m_next;
    logic [chisq_kt_pkg::LOG_W-1:0]       r_reg, r_next;
    logic [63:0]                          sq;
    logic [32:0]                          sq_sh;

    assign sq    = 64'(m_reg) * 64'(m_reg);
    assign sq_sh = sq[63:31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chisq_kt_pkg::LOG_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        p_reg <= p_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        v_next     = v_reg;
        p_next     = p_reg;
        m_next     = m_reg;
        r_next     = r_reg;
        unique case (state_reg)
            chisq_kt_pkg::LOG_IDLE:
            begin
                if (start)
                begin
                    v_next     = value;
                    p_next     = '1;
                    cnt_next   = '0;
                    state_next = chisq_kt_pkg::LOG_NORM;
                end
            end
            chisq_kt_pkg::LOG_NORM:
            begin
                // Binary search for the leading one, widest step first.
                case (cnt_reg)
                    5'd0:
                        if (v_reg[63:32] == '0)
                        begin
                            v_next = v_reg << 32;
                            p_next = p_reg - 6'd32;
                        end
                    5'd1:
                        if (v_reg[63:48] == '0)
                        begin
                            v_next = v_reg << 16;
                            p_next = p_reg - 6'd16;
                        end
                    5'd2:
                        if (v_reg[63:56] == '0)
                        begin
                            v_next = v_reg << 8;
                            p_next = p_reg - 6'd8;
                        end
                    5'd3:
                        if (v_reg[63:60] == '0)
                        begin
                            v_next = v_reg << 4;
                            p_next = p_reg - 6'd4;
                        end
                    5'd4:
                        if (v_reg[63:62] == '0)
                        begin
                            v_next = v_reg << 2;
                            p_next = p_reg - 6'd2;
                        end
                    default:
                        if (!v_reg[63])
                        begin
                            v_next = v_reg << 1;
                            p_next = p_reg - 6'd1;
                        end
                endcase
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'd5)
                begin
                    cnt_next   = '0;
                    state_next = chisq_kt_pkg::LOG_SQ;
                end
            end
            chisq_kt_pkg::LOG_SQ:
            begin
                if (cnt_reg == '0)
                begin
                    // The first step in this state loads the normalised mantissa.
                    m_next = v_reg[63:32];
                    r_next = chisq_kt_pkg::LOG_W'(p_reg);
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    m_next   = sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
                    r_next   = {r_reg[chisq_kt_pkg::LOG_W-2:0], sq_sh[32]};
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == chisq_kt_pkg::LOG_CNT_W'(chisq_kt_pkg::LOG_FRAC))
                    begin
                        done_next  = 1'b1;
                        state_next = chisq_kt_pkg::LOG_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = chisq_kt_pkg::LOG_IDLE;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

[src/chisq_kt_back.sv]
// Back end: sequencer that loads the training table, refreshes the weight and codes symbols.
module chisq_kt_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 training_length_we,
    input  logic [23:0]                          training_length,
    input  logic                                 q_valid,
    input  chisq_kt_pkg::item_t                  q_item,
    output logic                                 q_take,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [chisq_kt_pkg::LEN_W-1:0]       symbol_code_length,
    output logic [chisq_kt_pkg::TOTAL_W-1:0]     total_code_length,
    output logic [chisq_kt_pkg::WEIGHT_W-1:0]    weight,
    output logic                                 end_of_message
);

    localparam int CB = chisq_kt_pkg::COUNT_BITS;
    localparam int SW = chisq_kt_pkg::SYM_W;

    chisq_kt_pkg::back_state_t state_reg, state_next;

    logic [23:0]                        len_l_reg;
    logic [CB-1:0]                      pos_reg, pos_next;
    logic [CB:0]                        refresh_reg, refresh_next;
    logic [chisq_kt_pkg::WEIGHT_W-1:0]  w_reg, w_next;
    logic [chisq_kt_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [chisq_kt_pkg::ALPHABET_SIZE-1:0] pc_valid_reg, pc_valid_next;
    logic                               out_valid_reg, out_valid_next;

    logic [SW-1:0]                      x_reg, x_next;
    logic                               last_reg, last_next;
    logic [SW-1:0]                      idx_reg, idx_next;
    logic [CB-1:0]                      k_reg, k_next;
    logic [31:0]                        pa_reg, pa_next;
    logic [32:0]                        pb_reg, pb_next;
    logic [31:0]                        diff_reg, diff_next;
    logic [63:0]                        s1_reg, s1_next;
    logic [63:0]                        s2_reg, s2_next;
    logic [63:0]                        chi_reg, chi_next;
    logic [55:0]                        plo_reg, plo_next;
    logic [63:0]                        dsor_reg, dsor_next;
    logic [chisq_kt_pkg::LOG_W-1:0]     lnn_reg, lnn_next;
    logic [chisq_kt_pkg::LOG_W-1:0]     dif_reg, dif_next;
    logic [44:0]                        mlo_reg, mlo_next;
    logic [chisq_kt_pkg::LEN_W-1:0]     len_reg, len_next;
    logic [chisq_kt_pkg::LEN_W-1:0]     olen_reg, olen_next;
    logic [chisq_kt_pkg::TOTAL_W-1:0]   ototal_reg, ototal_next;
    logic [chisq_kt_pkg::WEIGHT_W-1:0]  ow_reg, ow_next;
    logic                               oend_reg, oend_next;

    // Memories and shared units.
    logic                               tbl_we, pc_we;
    logic [SW-1:0]                      raddr;
    logic [CB-1:0]                      tbl_rdata, pc_rdata, pc_wdata;
    logic                               div_start, div_done;
    logic [chisq_kt_pkg::DEND_W-1:0]    div_a, div_q;
    logic [chisq_kt_pkg::SOR_W-1:0]     div_b;
    logic                               log_start, log_done;
    logic [chisq_kt_pkg::LOG_IN_W-1:0]  log_v;
    logic [chisq_kt_pkg::LOG_W-1:0]     log_r;

    // Combinational helpers.
    logic [25:0]  ld;
    logic [CB-1:0] k_rd;
    logic [32:0]  pb_cap;
    logic [31:0]  pa_cap;
    logic [63:0]  q64;
    logic [63:0]  sq64, pr64;
    logic [31:0]  pb_neg;
    logic [55:0]  phi;
    logic [64:0]  e_sum;
    logic [63:0]  e_val;
    logic [63:0]  num_v, den_v;
    logic [44:0]  mhi;
    logic [63:0]  len_full;
    logic [22:0]  len_sh;
    logic [chisq_kt_pkg::TOTAL_W:0] tot_sum;
    logic [chisq_kt_pkg::WEIGHT_W:0] xi_round;
    logic         walk_last;

    chisq_kt_ram #(.WIDTH(CB), .DEPTH(chisq_kt_pkg::ALPHABET_SIZE)) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (q_item.symbol),
        .wdata (q_item.count),
        .raddr (raddr),
        .rdata (tbl_rdata)
    );

    chisq_kt_ram #(.WIDTH(CB), .DEPTH(chisq_kt_pkg::ALPHABET_SIZE)) u_pc_ram (
        .clk   (clk),
        .we    (pc_we),
        .waddr (x_reg),
        .wdata (pc_wdata),
        .raddr (raddr),
        .rdata (pc_rdata)
    );

    chisq_kt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    chisq_kt_log u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .value  (log_v),
        .done   (log_done),
        .result (log_r)
    );

    assign ld        = {1'b0, len_l_reg, 1'b0} + 26'(chisq_kt_pkg::ALPHABET_SIZE);
    assign k_rd      = pc_valid_reg[raddr] ? pc_rdata : '0;
    assign q64       = div_q[63:0];
    assign pa_cap    = (div_q > 66'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_q[31:0];
    assign pb_cap    = (div_q > 66'h1_0000_0000) ? 33'h1_0000_0000 : div_q[32:0];
    assign sq64      = 64'(diff_reg) * 64'(diff_reg);
    assign pb_neg    = 32'd0 - pb_reg[31:0];
    assign pr64      = 64'(pb_reg[31:0]) * 64'(pb_neg);
    assign phi       = 56'(len_l_reg) * 56'(chi_reg[63:32]);
    assign e_val     = (phi >= 56'h8000_0000) ? 64'h8000_0000_0000_0000
                                             : {phi[31:0], 32'd0} + 64'(plo_reg);
    assign e_sum     = {1'b0, e_val} + {25'd0, chisq_kt_pkg::DEGREES, 32'd0};
    assign num_v     = 64'(w_reg) * 64'(tbl_rdata) + {16'd0, k_rd, 24'd0} + 64'h80_0000;
    assign den_v     = 64'(w_reg) * 64'(len_l_reg) + {16'd0, pos_reg, 24'd0}
                     + (64'(chisq_kt_pkg::ALPHABET_SIZE) << 23);
    assign mhi       = 45'(dif_reg[35:18]) * 45'(chisq_kt_pkg::LN2_Q27);
    assign len_full  = {1'b0, mhi, 18'd0} + 64'(mlo_reg) + (64'd1 << (chisq_kt_pkg::LEN_SHIFT - 1));
    assign len_sh    = len_full[chisq_kt_pkg::LEN_SHIFT +: 23];
    assign tot_sum   = {1'b0, total_reg} + (chisq_kt_pkg::TOTAL_W + 1)'(len_reg);
    assign xi_round  = div_q[chisq_kt_pkg::WEIGHT_W:0] + 1'b1;
    assign walk_last = (idx_reg == SW'(chisq_kt_pkg::ALPHABET_SIZE - 1));
    assign pc_wdata  = (k_reg == chisq_kt_pkg::COUNT_MAX) ? k_reg : k_reg + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        refresh_next   = refresh_reg;
        w_next         = w_reg;
        total_next     = total_reg;
        pc_valid_next  = pc_valid_reg;
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        pa_next        = pa_reg;
        pb_next        = pb_reg;
        diff_next      = diff_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        chi_next       = chi_reg;
        plo_next       = plo_reg;
        dsor_next      = dsor_reg;
        lnn_next       = lnn_reg;
        dif_next       = dif_reg;
        mlo_next       = mlo_reg;
        len_next       = len_reg;
        olen_next      = olen_reg;
        ototal_next    = ototal_reg;
        ow_next        = ow_reg;
        oend_next      = oend_reg;
        q_take         = 1'b0;
        tbl_we         = 1'b0;
        pc_we          = 1'b0;
        raddr          = x_reg;
        div_start      = 1'b0;
        div_a          = '0;
        div_b          = '0;
        log_start      = 1'b0;
        log_v          = num_v;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            chisq_kt_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_take = 1'b1;
                    if (q_item.kind == chisq_kt_pkg::KIND_LOAD)
                    begin
                        tbl_we = 1'b1;
                    end
                    else
                    begin
                        x_next    = q_item.symbol;
                        last_next = q_item.last;
                        if ({1'b0, pos_reg} == refresh_reg)
                        begin
                            idx_next   = '0;
                            s1_next    = '0;
                            s2_next    = '0;
                            state_next = chisq_kt_pkg::ST_W_RD;
                        end
                        else
                        begin
                            state_next = chisq_kt_pkg::ST_RD;
                        end
                    end
                end
            end
            chisq_kt_pkg::ST_W_RD:
            begin
                raddr      = idx_reg;
                state_next = chisq_kt_pkg::ST_W_PA_GO;
            end
            chisq_kt_pkg::ST_W_PA_GO:
            begin
                raddr      = idx_reg;
                k_next     = k_rd;
                div_start  = 1'b1;
                div_a      = {9'd0, tbl_rdata, 1'b1, 32'd0};
                div_b      = 64'(ld);
                state_next = chisq_kt_pkg::ST_W_PA;
            end
            chisq_kt_pkg::ST_W_PA:
            begin
                if (div_done)
                begin
                    pa_next    = pa_cap;
                    div_start  = 1'b1;
                    div_a      = {10'd0, k_reg, 32'd0};
                    div_b      = 64'(pos_reg);
                    state_next = chisq_kt_pkg::ST_W_PB;
                end
            end
            chisq_kt_pkg::ST_W_PB:
            begin
                if (div_done)
                begin
                    pb_next    = pb_cap;
                    diff_next  = ({1'b0, pa_reg} > pb_cap) ? 32'({1'b0, pa_reg} - pb_cap)
                                                          : 32'(pb_cap - {1'b0, pa_reg});
                    state_next = chisq_kt_pkg::ST_W_T1_GO;
                end
            end
            chisq_kt_pkg::ST_W_T1_GO:
            begin
                div_start  = 1'b1;
                div_a      = 66'(sq64);
                div_b      = 64'(pa_reg);
                state_next = chisq_kt_pkg::ST_W_T1;
            end
            chisq_kt_pkg::ST_W_T1:
            begin
                if (div_done)
                begin
                    s1_next    = chisq_kt_pkg::sat_add64(s1_reg, q64);
                    state_next = chisq_kt_pkg::ST_W_T2_GO;
                end
            end
            chisq_kt_pkg::ST_W_T2_GO:
            begin
                div_start  = 1'b1;
                div_a      = 66'(pr64);
                div_b      = 64'(pa_reg);
                state_next = chisq_kt_pkg::ST_W_T2;
            end
            chisq_kt_pkg::ST_W_T2:
            begin
                if (div_done)
                begin
                    s2_next  = chisq_kt_pkg::sat_add64(s2_reg, q64);
                    idx_next = idx_reg + 1'b1;
                    state_next = walk_last ? chisq_kt_pkg::ST_CORR_GO : chisq_kt_pkg::ST_W_RD;
                end
            end
            chisq_kt_pkg::ST_CORR_GO:
            begin
                div_start  = 1'b1;
                div_a      = 66'(s2_reg);
                div_b      = 64'(pos_reg - 1'b1);
                state_next = chisq_kt_pkg::ST_CORR;
            end
            chisq_kt_pkg::ST_CORR:
            begin
                if (div_done)
                begin
                    chi_next   = (s1_reg > q64) ? s1_reg - q64 : '0;
                    state_next = chisq_kt_pkg::ST_E_LO;
                end
            end
            chisq_kt_pkg::ST_E_LO:
            begin
                plo_next   = 56'(len_l_reg) * 56'(chi_reg[31:0]);
                state_next = chisq_kt_pkg::ST_E_HI;
            end
            chisq_kt_pkg::ST_E_HI:
            begin
                dsor_next  = (e_sum > 65'h0_8000_0000_0000_0000) ? 64'h8000_0000_0000_0000
                                                                 : e_sum[63:0];
                state_next = chisq_kt_pkg::ST_XI_GO;
            end
            chisq_kt_pkg::ST_XI_GO:
            begin
                div_start  = 1'b1;
                div_a      = {1'b0, chisq_kt_pkg::DEGREES, 57'd0};
                div_b      = dsor_reg;
                state_next = chisq_kt_pkg::ST_XI;
            end
            chisq_kt_pkg::ST_XI:
            begin
                if (div_done)
                begin
                    w_next = xi_round[chisq_kt_pkg::WEIGHT_W:1];
                    if (!refresh_reg[CB])
                    begin
                        refresh_next = refresh_reg << 1;
                    end
                    state_next = chisq_kt_pkg::ST_RD;
                end
            end
            chisq_kt_pkg::ST_RD:
            begin
                state_next = chisq_kt_pkg::ST_NUM;
            end
            chisq_kt_pkg::ST_NUM:
            begin
                k_next     = k_rd;
                log_start  = 1'b1;
                log_v      = num_v;
                state_next = chisq_kt_pkg::ST_LN_NUM;
            end
            chisq_kt_pkg::ST_LN_NUM:
            begin
                if (log_done)
                begin
                    lnn_next   = log_r;
                    log_start  = 1'b1;
                    log_v      = den_v;
                    state_next = chisq_kt_pkg::ST_LN_DEN;
                end
            end
            chisq_kt_pkg::ST_LN_DEN:
            begin
                if (log_done)
                begin
                    dif_next   = (log_r > lnn_reg) ? log_r - lnn_reg : '0;
                    state_next = chisq_kt_pkg::ST_M_LO;
                end
            end
            chisq_kt_pkg::ST_M_LO:
            begin
                mlo_next   = 45'(dif_reg[17:0]) * 45'(chisq_kt_pkg::LN2_Q27);
                state_next = chisq_kt_pkg::ST_M_HI;
            end
            chisq_kt_pkg::ST_M_HI:
            begin
                len_next   = (len_sh > 23'(chisq_kt_pkg::LEN_MAX)) ? chisq_kt_pkg::LEN_MAX
                                                                   : len_sh[chisq_kt_pkg::LEN_W-1:0];
                state_next = chisq_kt_pkg::ST_OUT;
            end
            chisq_kt_pkg::ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    olen_next      = len_reg;
                    ototal_next    = tot_sum[chisq_kt_pkg::TOTAL_W] ? chisq_kt_pkg::TOTAL_MAX
                                                                    : tot_sum[chisq_kt_pkg::TOTAL_W-1:0];
                    ow_next        = w_reg;
                    oend_next      = last_reg;
                    pc_we          = 1'b1;
                    pc_valid_next[x_reg] = 1'b1;
                    total_next     = ototal_next;
                    if (pos_reg != chisq_kt_pkg::COUNT_MAX)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (last_reg)
                    begin
                        pc_valid_next = '0;
                        pos_next      = '0;
                        refresh_next  = (CB + 1)'(2);
                        w_next        = chisq_kt_pkg::WEIGHT_ONE;
                        total_next    = '0;
                    end
                    state_next = chisq_kt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = chisq_kt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chisq_kt_pkg::ST_IDLE;
            len_l_reg     <= 24'd1;
            pos_reg       <= '0;
            refresh_reg   <= (CB + 1)'(2);
            w_reg         <= chisq_kt_pkg::WEIGHT_ONE;
            total_reg     <= '0;
            pc_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (training_length_we)
            begin
                len_l_reg <= training_length;
            end
            pos_reg       <= pos_next;
            refresh_reg   <= refresh_next;
            w_reg         <= w_next;
            total_reg     <= total_next;
            pc_valid_reg  <= pc_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        pa_reg     <= pa_next;
        pb_reg     <= pb_next;
        diff_reg   <= diff_next;
        s1_reg     <= s1_next;
        s2_reg     <= s2_next;
        chi_reg    <= chi_next;
        plo_reg    <= plo_next;
        dsor_reg   <= dsor_next;
        lnn_reg    <= lnn_next;
        dif_reg    <= dif_next;
        mlo_reg    <= mlo_next;
        len_reg    <= len_next;
        olen_reg   <= olen_next;
        ototal_reg <= ototal_next;
        ow_reg     <= ow_next;
        oend_reg   <= oend_next;
    end

    assign out_valid          = out_valid_reg;
    assign symbol_code_length = olen_reg;
    assign total_code_length  = ototal_reg;
    assign weight             = ow_reg;
    assign end_of_message     = oend_reg;

endmodule

[src/chi_square_weighted_kt_code_length_core.sv]
// Top level of the weighted KT code-length core: front queue and back sequencer.
//
// This core streams message bytes through a Krichevsky-Trofimov estimator that is
// blended with a training prior. Load transfers (mode 0) write one entry of the
// 256-entry training-count table and give no result; code transfers (mode 1) give
// one result each, holding the symbol's code length in UQ5.16 nats, the running
// total in UQ30.16 and the weight in use in UQ1.24. The weight starts at one and
// is recomputed from a debiased chi-square divergence when the message position
// reaches 2, 4, 8 and so on; after a symbol flagged as last, the prefix counts,
// position, total and weight return to their reset values. An accepted transfer
// is registered in the front queue before the back end can take it. The back end
// writes a load into the table from its idle state; a code transfer is paced by
// the shared logarithm unit, which runs twice per symbol (six normalisation steps,
// one mantissa load, thirty squaring steps and a registered hand-over of the
// result). At a refresh position a walk over all 256 symbols comes first, with
// four 66-step divisions in the shared divider for each symbol. A two-entry queue
// at the input accepts transfers while the back end works or while a result waits
// in the output register, until it is full and raises in_stall. The training
// length is written through training_length_we and training_length; the user must
// write it only while the core is idle, which the core itself does not enforce.
module chi_square_weighted_kt_code_length_core (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     training_length_we,
    input  logic [23:0]                              training_length,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic                                     mode,
    input  logic [7:0]                               symbol,
    input  logic [23:0]                              training_count,
    input  logic                                     last_symbol,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [20:0]                              symbol_code_length,
    output logic [45:0]                              total_code_length,
    output logic [24:0]                              weight,
    output logic                                     end_of_message
);

    // Items travel from the front queue to the back sequencer one at a time.
    logic                q_valid;
    logic                q_take;
    chisq_kt_pkg::item_t q_item;

    chisq_kt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .symbol         (symbol),
        .training_count (training_count),
        .last_symbol    (last_symbol),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_take         (q_take)
    );

    // The back end owns both tables, the divider and the logarithm unit.
    chisq_kt_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .training_length_we (training_length_we),
        .training_length    (training_length),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_take             (q_take),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .symbol_code_length (symbol_code_length),
        .total_code_length  (total_code_length),
        .weight             (weight),
        .end_of_message     (end_of_message)
    );

endmodule

[src/chisq_kt_checker.sv]
// Port-level checks of the weighted KT code-length core, bound to the top level.
module chisq_kt_props (
    input logic        clk,
    input logic        rst_n,
    input logic        training_length_we,
    input logic [23:0] training_length,
    input logic        in_valid,
    input logic        in_stall,
    input logic        mode,
    input logic [7:0]  symbol,
    input logic [23:0] training_count,
    input logic        last_symbol,
    input logic        out_valid,
    input logic        out_stall,
    input logic [20:0] symbol_code_length,
    input logic [45:0] total_code_length,
    input logic [24:0] weight,
    input logic        end_of_message
);

    // A stalled result must stay offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // The total and weight of a stalled result must not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(total_code_length) && $stable(weight))
        else $error("stalled result changed");

    // The weight never exceeds one.
    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> weight <= chisq_kt_pkg::WEIGHT_ONE)
        else $error("weight above one");

    // The running total always includes the symbol just coded.
    a_total_ge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> total_code_length >= 46'(symbol_code_length))
        else $error("total below symbol length");

endmodule

bind chi_square_weighted_kt_code_length_core chisq_kt_props u_props (.*);

[dv/chisq_kt_checker.sv]
// Channel monitor, code-length predictor and result comparator of the weighted KT core.
`timescale 1ns / 100ps

module chisq_kt_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                training_length_we,
    input  logic [23:0]                         training_length,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                mode,
    input  logic [7:0]                          symbol,
    input  logic [23:0]                         training_count,
    input  logic                                last_symbol,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [chisq_kt_pkg::LEN_W-1:0]      symbol_code_length,
    input  logic [chisq_kt_pkg::TOTAL_W-1:0]    total_code_length,
    input  logic [chisq_kt_pkg::WEIGHT_W-1:0]   weight,
    input  logic                                end_of_message,
    output int                                  outstanding,
    output int                                  mismatches
);

    typedef struct packed {
        logic [chisq_kt_pkg::LEN_W-1:0]    len;
        logic [chisq_kt_pkg::TOTAL_W-1:0]  total;
        logic [chisq_kt_pkg::WEIGHT_W-1:0] wt;
        logic                              eom;
    } code_result_t;

    localparam bit [63:0] Q32 = 64'd1 << 32;

    code_result_t expected_codes[$];

    bit [63:0] len_reg;
    bit [63:0] count_tbl[256];
    bit [63:0] prefix_tbl[256];
    bit [63:0] pos;
    bit [63:0] refresh_at;
    bit [63:0] cur_wt;
    bit [63:0] msg_total;

    function automatic bit [63:0] add_sat64(bit [63:0] a, bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    // Base-2 logarithm with 30 fraction bits, by repeated squaring of the mantissa.
    function automatic bit [63:0] log2_q30(bit [63:0] v);
        int p;
        bit [63:0] m;
        bit [63:0] r;
        p = 63;
        while (p > 0 && !v[p])
            p--;
        m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
        r = 64'(p);
        for (int i = 0; i < 30; i++)
        begin
            m = (m * m) >> 31;
            r = r << 1;
            if (m >= Q32)
            begin
                r[0] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    // Weight from the debiased chi-square divergence between prior and prefix.
    function automatic bit [63:0] chi_square_weight(bit [63:0] t);
        bit [63:0] ld, s1, s2, chi, corr, e, dv, r, q, plo, phi, pa, pb, diff;
        bit [63:0] d;
        ld = 2 * len_reg + 64'd256;
        s1 = 0;
        s2 = 0;
        d = 64'd255;
        for (int x = 0; x < 256; x++)
        begin
            pa = ((2 * count_tbl[x] + 1) << 32) / ld;
            pb = (prefix_tbl[x] << 32) / t;
            if (pa > Q32 - 1)
                pa = Q32 - 1;
            if (pb > Q32)
                pb = Q32;
            diff = (pa > pb) ? pa - pb : pb - pa;
            s1 = add_sat64(s1, (diff * diff) / pa);
            s2 = add_sat64(s2, (pb * (Q32 - pb)) / pa);
        end
        corr = s2 / (t - 1);
        chi = (s1 > corr) ? s1 - corr : 64'd0;
        plo = len_reg * (chi & 64'hFFFF_FFFF);
        phi = len_reg * (chi >> 32);
        if (phi >= (64'd1 << 31))
            e = 64'd1 << 63;
        else
            e = (phi << 32) + plo;
        dv = e + (d << 32);
        if (dv > (64'd1 << 63))
            dv = 64'd1 << 63;
        r = d << 32;
        q = 0;
        for (int i = 0; i < 26; i++)
        begin
            q = q << 1;
            if (r >= dv)
            begin
                r = r - dv;
                q[0] = 1'b1;
            end
            r = r << 1;
        end
        return (q + 1) >> 1;
    endfunction

    function automatic void clear_message_state();
        foreach (prefix_tbl[i])
            prefix_tbl[i] = 0;
        pos = 0;
        refresh_at = 2;
        cur_wt = 64'd1 << 24;
        msg_total = 0;
    endfunction

    function automatic code_result_t code_symbol(bit [7:0] sym, bit last);
        code_result_t res;
        bit [63:0] t, num, den, lnum, lden, len;
        t = pos;
        if (t == refresh_at)
        begin
            cur_wt = chi_square_weight(t);
            if (refresh_at < (64'd1 << 62))
                refresh_at = refresh_at << 1;
        end
        num = cur_wt * count_tbl[sym] + (prefix_tbl[sym] << 24) + (64'd1 << 23);
        den = cur_wt * len_reg + (t << 24) + (64'd256 << 23);
        lnum = log2_q30(num);
        lden = log2_q30(den);
        if (lden > lnum)
        begin
            len = ((lden - lnum) * 64'd93032640
                   + (64'd1 << (chisq_kt_pkg::LEN_SHIFT - 1))) >> chisq_kt_pkg::LEN_SHIFT;
            if (len > 64'(chisq_kt_pkg::LEN_MAX))
                len = 64'(chisq_kt_pkg::LEN_MAX);
        end
        else
            len = 0;
        msg_total = msg_total + len;
        if (msg_total > 64'(chisq_kt_pkg::TOTAL_MAX))
            msg_total = 64'(chisq_kt_pkg::TOTAL_MAX);
        if (prefix_tbl[sym] < 64'(chisq_kt_pkg::COUNT_MAX))
            prefix_tbl[sym]++;
        if (pos < 64'(chisq_kt_pkg::COUNT_MAX))
            pos++;
        res.len = len[chisq_kt_pkg::LEN_W-1:0];
        res.total = msg_total[chisq_kt_pkg::TOTAL_W-1:0];
        res.wt = cur_wt[chisq_kt_pkg::WEIGHT_W-1:0];
        res.eom = last;
        if (last)
            clear_message_state();
        return res;
    endfunction

    assign outstanding = expected_codes.size();

    always @(posedge clk or negedge rst_n)
    begin
        code_result_t exp_r;
        code_result_t got_r;
        if (!rst_n)
        begin
            expected_codes.delete();
            mismatches <= 0;
            len_reg = 1;
            foreach (count_tbl[i])
                count_tbl[i] = 0;
            clear_message_state();
        end
        else
        begin
            if (training_length_we)
                len_reg = 64'(training_length);
            // Compare first: a result never belongs to the transfer of the same edge.
            if (out_valid && !out_stall)
            begin
                got_r = '{symbol_code_length, total_code_length, weight, end_of_message};
                if (expected_codes.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing expected: len %0d total %0d wt %0d",
                                 $realtime, got_r.len, got_r.total, got_r.wt);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_r = expected_codes.pop_front();
                    if (got_r !== exp_r)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch: len %0d/%0d total %0d/%0d ",
                                      "weight %0d/%0d eom %0d/%0d (expected/actual)"},
                                     $realtime, exp_r.len, got_r.len, exp_r.total,
                                     got_r.total, exp_r.wt, got_r.wt, exp_r.eom, got_r.eom);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (mode == chisq_kt_pkg::KIND_LOAD)
                    count_tbl[symbol] = 64'(training_count);
                else
                    expected_codes.push_back(code_symbol(symbol, last_symbol));
            end
        end
    end

endmodule

[dv/tb_chi_square_weighted_kt_code_length_core.sv]
// Stimulus, clock, reset and verdict for the weighted KT code-length core.
`timescale 1ns / 100ps

module tb_chi_square_weighted_kt_code_length_core;

    // The cycle limit leaves ample room for the refresh walks that the stimulus causes,
    // even with heavy output stalls.
    localparam longint CYCLE_LIMIT = 8_000_000;
    localparam int     RAND_ITEMS  = 1500;
    localparam int     SEGMENTS    = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        training_length_we = 1'b0;
    logic [23:0] training_length = 24'd0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = chisq_kt_pkg::KIND_LOAD;
    logic [7:0]  symbol = 8'd0;
    logic [23:0] training_count = 24'd0;
    logic        last_symbol = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [20:0] symbol_code_length;
    logic [45:0] total_code_length;
    logic [24:0] weight;
    logic        end_of_message;

    int     outstanding;
    int     mismatches;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     n_loads = 0;
    int     n_codes = 0;
    int     n_settings = 0;
    longint cycles = 0;

    always #6 clk = ~clk;

    chi_square_weighted_kt_code_length_core i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .training_length_we (training_length_we),
        .training_length    (training_length),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode               (mode),
        .symbol             (symbol),
        .training_count     (training_count),
        .last_symbol        (last_symbol),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .symbol_code_length (symbol_code_length),
        .total_code_length  (total_code_length),
        .weight             (weight),
        .end_of_message     (end_of_message)
    );

    chisq_kt_checker i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .training_length_we (training_length_we),
        .training_length    (training_length),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode               (mode),
        .symbol             (symbol),
        .training_count     (training_count),
        .last_symbol        (last_symbol),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .symbol_code_length (symbol_code_length),
        .total_code_length  (total_code_length),
        .weight             (weight),
        .end_of_message     (end_of_message),
        .outstanding        (outstanding),
        .mismatches         (mismatches)
    );

    // The receiver holds off at random; the share of stalled cycles is set per phase.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // Watchdog: a hung core or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // One transfer on the input channel. Entered and left at a falling edge; valid is
    // lowered only when a gap is taken, so it never gets two updates in one step.
    task automatic push_item(input chisq_kt_pkg::kind_t k, input logic [7:0] sym,
                             input logic [23:0] cnt, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= k;
        symbol         <= sym;
        training_count <= cnt;
        last_symbol    <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        if (k == chisq_kt_pkg::KIND_LOAD)
            n_loads++;
        else
            n_codes++;
    endtask

    // Waits until every expected result has come, then lets loads still queued in the
    // core drain before anything else happens.
    task automatic drain_core();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_training_length(input logic [23:0] val);
        drain_core();
        training_length_we <= 1'b1;
        training_length    <= val;
        @(negedge clk);
        training_length_we <= 1'b0;
        n_settings++;
    endtask

    // Counts spread over all magnitudes, so that both small and huge priors occur.
    function automatic logic [23:0] random_count();
        int bits;
        bits = $urandom_range(0, 24);
        if (bits == 0)
            return 24'd0;
        return 24'($urandom) & ((24'd1 << bits) - 24'd1) | (24'd1 << (bits - 1));
    endfunction

    initial
    begin
        logic [23:0] seg_len [SEGMENTS];
        int          msg_len;
        int          per_seg;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every table entry is written before any code transfer, since a refresh walk
        // reads the whole table.
        for (int s = 0; s < 256; s++)
            push_item(chisq_kt_pkg::KIND_LOAD, 8'(s), random_count(), 1'($urandom));

        // Directed part, under the reset training length of one: extreme counts,
        // a count above the training length, and a message long enough to pass
        // the refreshes at positions two, four and eight.
        push_item(chisq_kt_pkg::KIND_LOAD, 8'd0, 24'd0, 1'b0);
        push_item(chisq_kt_pkg::KIND_LOAD, 8'd255, 24'hFF_FFFF, 1'b1);
        push_item(chisq_kt_pkg::KIND_LOAD, 8'd128, 24'd1, 1'b0);
        push_item(chisq_kt_pkg::KIND_CODE, 8'd0, 24'hFF_FFFF, 1'b1);
        push_item(chisq_kt_pkg::KIND_CODE, 8'd255, 24'd0, 1'b1);
        push_item(chisq_kt_pkg::KIND_CODE, 8'd128, 24'd0, 1'b0);
        push_item(chisq_kt_pkg::KIND_CODE, 8'd128, 24'd0, 1'b1);
        for (int i = 0; i < 9; i++)
            push_item(chisq_kt_pkg::KIND_CODE, (i < 5) ? 8'd0 : 8'd255, 24'($urandom),
                      (i == 8));

        // A zero training length, then the largest one, each with a short refreshed
        // message where the weight may fall to its floor.
        set_training_length(24'd0);
        for (int i = 0; i < 3; i++)
            push_item(chisq_kt_pkg::KIND_CODE, 8'(i), 24'd0, (i == 2));
        set_training_length(24'hFF_FFFF);
        for (int i = 0; i < 3; i++)
            push_item(chisq_kt_pkg::KIND_CODE, 8'd0, 24'd0, (i == 2));

        // Random part: six segments under different training lengths. Messages are
        // mostly one or two symbols long; rarely one runs past one or two refreshes.
        seg_len = '{24'd1, 24'hFF_FFFF, 24'd0, 24'($urandom), 24'($urandom_range(2, 300)), 24'd255};
        per_seg = RAND_ITEMS / SEGMENTS;
        for (int sg = 0; sg < SEGMENTS; sg++)
        begin
            set_training_length(seg_len[sg]);
            case (sg / 2)
                0: begin send_idle_pct = 29; recv_idle_pct = 73; end
                1: begin send_idle_pct = 73; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < per_seg; )
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_item(chisq_kt_pkg::KIND_LOAD, 8'($urandom), random_count(),
                              1'($urandom));
                    n++;
                end
                else
                begin
                    msg_len = ($urandom_range(0, 399) == 0) ? $urandom_range(3, 5)
                                                            : $urandom_range(1, 2);
                    for (int j = 0; j < msg_len; j++)
                        push_item(chisq_kt_pkg::KIND_CODE, 8'($urandom), 24'($urandom),
                                  (j == msg_len - 1));
                    n += msg_len;
                end
            end
        end

        drain_core();
        $display("Covered %0d load and %0d code transfers under %0d training-length settings,",
                 n_loads, n_codes, n_settings);
        $display("with sender and receiver stalls in three proportions.");
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
